FILE: design/bbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared constants, types and bit search helpers for the bitmap bit search.
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORDS     = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = $clog2(WORDS);
  localparam int POS_W     = WIDX_W + BIT_W;
  localparam int SIZE_W    = POS_W + 1;
  localparam int TOTAL_BITS = WORDS * WORD_BITS;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;
  localparam logic [1:0] MODE_NEXT  = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2048);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TOTAL_BITS);

  typedef struct packed {
    logic [1:0]           mode;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_data;
    logic                 search_value;
    logic [11:0]          start_position;
  } scan_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } scan_res_t;

  // lowest set bit of a word
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // highest set bit of a word
  function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: design/bitmap_bit_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_bit_search_core
// Bitmap of 64 x 32-bit words with write, find first, find last, find next.
// ----------------------------------------------------------------------------
// Order: a write passes from acceptance through the done state to the output
// register; a query reads words in turn until a match or its last word.
// Throughput: one item at a time, set by the single read port of the word
// memory that a query scans one word per cycle.
// Reset: control state clears and bitmap_bits returns to 2048; the bitmap
// words stay undefined until written.
module bitmap_bit_search_core import bbs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [5:0] word_index, [37:6] word_data, [38] search_value,
  // [50:39] start_position, [55:51] zero
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [10:0] position, [15:11] zero
  output logic      [15:0] m_axis_tdata,
  // [0] found
  output logic             m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [SIZE_W-1:0] size;
  scan_req_t         req;
  scan_res_t         res;
  logic              scan_idle, scan_done, out_free, start;
  logic              out_vld_q, out_vld_d;
  scan_res_t         out_q;

  bbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  assign req.mode           = s_axis_tuser;
  assign req.word_index     = s_axis_tdata[5:0];
  assign req.word_data      = s_axis_tdata[37:6];
  assign req.search_value   = s_axis_tdata[38];
  assign req.start_position = s_axis_tdata[50:39];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = scan_idle;
  assign start         = s_axis_tvalid && scan_idle;

  bbs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size),
    .start_i    (start),
    .req_i      (req),
    .idle_o     (scan_idle),
    .out_free_i (out_free),
    .done_o     (scan_done),
    .res_o      (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tready) out_vld_d = 1'b0;
    if (scan_done) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_q.position};
  assign m_axis_tuser  = out_q.found;

endmodule
`default_nettype wire

FILE: design/bbs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_cfg
// APB register file holding the bitmap size in use.
// ----------------------------------------------------------------------------
module bbs_cfg import bbs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [SIZE_W-1:0] size_o
);

  localparam logic [2:0] ADDR_BITMAP_BITS = 3'd0;

  logic [11:0] bits_q, bits_d;

  assign pready = 1'b1;

  always_comb begin
    bits_d = bits_q;
    if (psel && penable && pwrite && paddr == ADDR_BITMAP_BITS) begin
      bits_d = pwdata[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= SIZE_RESET;
    end else begin
      bits_q <= bits_d;
    end
  end

  assign prdata = (paddr == ADDR_BITMAP_BITS) ? {20'd0, bits_q} : 32'd0;

  // clamp to the bitmap capacity
  assign size_o = (bits_q > SIZE_MAX) ? SIZE_MAX : bits_q;

endmodule
`default_nettype wire

FILE: design/bbs_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_scan
// Bitmap word memory and the word-per-cycle search engine.
// ----------------------------------------------------------------------------
module bbs_scan import bbs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SIZE_W-1:0] size_i,
  input  wire logic              start_i,
  input  wire scan_req_t         req_i,
  output logic                   idle_o,
  input  wire logic              out_free_i,
  output logic                   done_o,
  output scan_res_t              res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [WIDX_W-1:0]    issue_q, issue_d;
  logic                 issuing_q, issuing_d;
  logic                 down_q, down_d;
  logic [WIDX_W-1:0]    end_w_q, end_w_d;
  logic [WIDX_W-1:0]    hi_w_q, hi_w_d;
  logic [BIT_W-1:0]     hi_b_q, hi_b_d;
  logic [WIDX_W-1:0]    lo_w_q, lo_w_d;
  logic [BIT_W-1:0]     lo_b_q, lo_b_d;
  logic                 val_q, val_d;
  logic                 rv_q, rv_d;
  logic [WIDX_W-1:0]    rw_q, rw_d;
  logic                 rl_q, rl_d;
  scan_res_t            res_q, res_d;

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [POS_W-1:0]     last_pos;
  logic                 empty;
  logic [WORD_BITS-1:0] hi_mask, lo_mask, match;

  assign last_pos = POS_W'(size_i - SIZE_W'(1));
  assign empty    = (size_i == '0) ||
                    (req_i.mode == MODE_NEXT && req_i.start_position >= size_i);

  always_comb begin
    hi_mask = '1;
    lo_mask = '1;
    if (rw_q == hi_w_q) hi_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_b_q);
    if (rw_q == lo_w_q) lo_mask = {WORD_BITS{1'b1}} << lo_b_q;
    match = (val_q ? rdata_q : ~rdata_q) & hi_mask & lo_mask;
  end

  always_comb begin
    state_d   = state_q;
    issue_d   = issue_q;
    issuing_d = issuing_q;
    down_d    = down_q;
    end_w_d   = end_w_q;
    hi_w_d    = hi_w_q;
    hi_b_d    = hi_b_q;
    lo_w_d    = lo_w_q;
    lo_b_d    = lo_b_q;
    val_d     = val_q;
    rv_d      = 1'b0;
    rw_d      = rw_q;
    rl_d      = rl_q;
    res_d     = res_q;
    done_o    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          val_d  = req_i.search_value;
          hi_w_d = last_pos[POS_W-1:BIT_W];
          hi_b_d = last_pos[BIT_W-1:0];
          lo_w_d = '0;
          lo_b_d = '0;
          down_d = 1'b0;
          issue_d = '0;
          end_w_d = last_pos[POS_W-1:BIT_W];
          if (req_i.mode == MODE_WRITE || empty) begin
            state_d = ST_DONE;
          end else begin
            state_d   = ST_RUN;
            issuing_d = 1'b1;
            if (req_i.mode == MODE_NEXT) begin
              issue_d = req_i.start_position[POS_W-1:BIT_W];
              lo_w_d  = req_i.start_position[POS_W-1:BIT_W];
              lo_b_d  = req_i.start_position[BIT_W-1:0];
            end else if (req_i.mode == MODE_LAST) begin
              down_d  = 1'b1;
              issue_d = last_pos[POS_W-1:BIT_W];
              end_w_d = '0;
            end
          end
        end
      end
      ST_RUN: begin
        // issue the next word read while the previous one is checked
        if (issuing_q) begin
          rv_d = 1'b1;
          rw_d = issue_q;
          rl_d = (issue_q == end_w_q);
          if (issue_q == end_w_q) issuing_d = 1'b0;
          else issue_d = down_q ? issue_q - WIDX_W'(1) : issue_q + WIDX_W'(1);
        end
        if (rv_q && match != '0) begin
          res_d.found    = 1'b1;
          res_d.position = {rw_q, down_q ? high_bit(match) : low_bit(match)};
          state_d        = ST_DONE;
          issuing_d      = 1'b0;
          rv_d           = 1'b0;
        end else if (rv_q && rl_q) begin
          state_d   = ST_DONE;
          issuing_d = 1'b0;
          rv_d      = 1'b0;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d   = ST_IDLE;
        issuing_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issuing_q <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      issuing_q <= issuing_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q <= issue_d;
    down_q  <= down_d;
    end_w_q <= end_w_d;
    hi_w_q  <= hi_w_d;
    hi_b_q  <= hi_b_d;
    lo_w_q  <= lo_w_d;
    lo_b_q  <= lo_b_d;
    val_q   <= val_d;
    rw_q    <= rw_d;
    rl_q    <= rl_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i && req_i.mode == MODE_WRITE) begin
      mem_q[req_i.word_index] <= req_i.word_data;
    end
    rdata_q <= mem_q[issue_q];
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: tb/bitmap_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_search_checker
// Keeps its own copy of the bitmap and of the size register, taken from the
// items and register writes it observes. It works out the answer to every
// accepted item and compares each result with the oldest answer still owed.
// ----------------------------------------------------------------------------
module bitmap_search_checker import bbs_pkg::*; #(
  parameter logic [2:0] SIZE_REG_ADDR = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          outstanding
);

  logic [WORD_BITS-1:0] bitmap_copy [WORDS];
  logic [SIZE_W-1:0]    bitmap_bits_copy;
  scan_res_t            owed_answers [$];
  int                   mismatches;

  // Walk the positions one by one, upward or downward, within the size.
  function automatic scan_res_t search_bitmap(scan_req_t req);
    scan_res_t hit;
    int        limit;
    int        p;
    int        step;
    hit = '0;
    limit = (bitmap_bits_copy > SIZE_MAX) ? TOTAL_BITS : int'(bitmap_bits_copy);
    if (req.mode == MODE_LAST) begin
      p    = limit - 1;
      step = -1;
    end else begin
      p    = (req.mode == MODE_NEXT) ? int'(req.start_position) : 0;
      step = 1;
    end
    if (req.mode != MODE_WRITE) begin
      while (!hit.found && p >= 0 && p < limit) begin
        if (bitmap_copy[p / WORD_BITS][p % WORD_BITS] == req.search_value) begin
          hit.found    = 1'b1;
          hit.position = POS_W'(p);
        end
        p += step;
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_req_t req;
    scan_res_t want;
    if (!rst_ni) begin
      bitmap_bits_copy = SIZE_RESET;
      owed_answers.delete();
      mismatches = 0;
      error_count <= 0;
      outstanding <= 0;
    end else begin
      // results first: an item's result can never leave at its own accept edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_answers.size() == 0) begin
          $error("result with no item outstanding: found %0d position %0d",
                 m_axis_tuser, m_axis_tdata[POS_W-1:0]);
          mismatches++;
        end else begin
          want = owed_answers.pop_front();
          if (m_axis_tuser !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[POS_W-1:0] !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d",
                   want.position, m_axis_tdata[POS_W-1:0]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.mode           = s_axis_tuser;
        req.word_index     = s_axis_tdata[WIDX_W-1:0];
        req.word_data      = s_axis_tdata[WIDX_W +: WORD_BITS];
        req.search_value   = s_axis_tdata[WIDX_W + WORD_BITS];
        req.start_position = s_axis_tdata[WIDX_W + WORD_BITS + 1 +: 12];
        owed_answers.push_back(search_bitmap(req));
        if (req.mode == MODE_WRITE) bitmap_copy[req.word_index] = req.word_data;
      end
      if (psel && penable && pwrite && pready && paddr == SIZE_REG_ADDR) begin
        bitmap_bits_copy = pwdata[SIZE_W-1:0];
      end
      error_count <= mismatches;
      outstanding <= owed_answers.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the bitmap bit search core: fills every word, runs a directed set of
// edge searches over several sizes, then random writes and searches under
// three idling schemes. A checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb import bbs_pkg::*;;

  localparam logic [2:0] REG_BITMAP_BITS = 3'd0;
  localparam int         WATCHDOG_LIMIT  = 4000;
  localparam int         SETTLE_CYCLES   = 80;
  localparam int         SEGMENTS        = 12;
  localparam int         SEGMENT_ITEMS   = 40;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [5:0] word_index, [37:6] word_data, [38] search_value,
  // [50:39] start_position, [55:51] zero
  logic [55:0] s_axis_tdata  = '0;
  // [1:0] mode
  logic [1:0]  s_axis_tuser  = MODE_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [10:0] position, [15:11] zero
  logic [15:0] m_axis_tdata;
  // [0] found
  logic        m_axis_tuser;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = REG_BITMAP_BITS;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int                error_count;
  int                outstanding;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  int                stall_cycles = 0;
  logic [SIZE_W-1:0] cur_size = SIZE_RESET;

  bitmap_bit_search_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bitmap_search_checker #(.SIZE_REG_ADDR(REG_BITMAP_BITS)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .error_count, .outstanding
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(9, 0))
      0, 1, 2: return '0;
      3, 4, 5: return '1;
      6:       return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1, 0);
      7:       return ~(WORD_BITS'(1) << $urandom_range(WORD_BITS - 1, 0));
      default: return WORD_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9, 0))
      0:          return '0;
      1:          return SIZE_MAX;
      2:          return SIZE_W'($urandom_range(4095, TOTAL_BITS + 1));
      3:          return SIZE_W'(WORD_BITS * $urandom_range(WORDS, 1));
      4, 5, 6:    return SIZE_W'($urandom_range(96, 1));
      default:    return SIZE_W'($urandom_range(TOTAL_BITS, 0));
    endcase
  endfunction

  // Valid stays high from one item to the next unless the sender idles.
  task automatic send_item(logic [1:0] mode, logic [WIDX_W-1:0] idx,
                           logic [WORD_BITS-1:0] data, logic val, logic [11:0] start);
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99, 0) < tx_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b0, start, val, data, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_word(logic [WIDX_W-1:0] idx, logic [WORD_BITS-1:0] data);
    send_item(MODE_WRITE, idx, data, 1'($urandom()), 12'($urandom()));
  endtask

  task automatic run_query(logic [1:0] mode, logic val, logic [11:0] start);
    send_item(mode, WIDX_W'($urandom()), WORD_BITS'($urandom()), val, start);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BITMAP_BITS;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    cur_size = value;
  endtask

  task automatic random_item();
    int eff;
    int start;
    eff = (cur_size > SIZE_MAX) ? TOTAL_BITS : int'(cur_size);
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: start = $urandom_range(eff, 0);
      6, 7:             start = eff - $urandom_range((eff < 3) ? eff : 3, 0);
      8:                start = eff;
      default:          start = $urandom_range(4095, 0);
    endcase
    send_item(2'($urandom_range(3, 0)), WIDX_W'($urandom()), pick_word(),
              1'($urandom()), 12'(start));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 11;
    rx_idle_pct = 85;
    write_size(SIZE_MAX);

    // every word gets written before any search can read it
    for (int w = 0; w < WORDS; w++) load_word(WIDX_W'(w), pick_word());

    // directed: full size, both ends of the map and of the start range
    load_word('0, '0);
    load_word('1, '1);
    run_query(MODE_FIRST, 1'b1, '0);
    run_query(MODE_FIRST, 1'b0, '0);
    run_query(MODE_LAST, 1'b1, '0);
    run_query(MODE_LAST, 1'b0, '1);
    run_query(MODE_NEXT, 1'b1, '0);
    run_query(MODE_NEXT, 1'b0, 12'(TOTAL_BITS - 1));
    run_query(MODE_NEXT, 1'b1, 12'(TOTAL_BITS));
    run_query(MODE_NEXT, 1'b0, '1);
    load_word(WIDX_W'(WORDS - 1), 32'h8000_0000);
    run_query(MODE_LAST, 1'b1, '0);
    run_query(MODE_LAST, 1'b0, '0);
    load_word('0, 32'hFFFF_FFFE);
    run_query(MODE_FIRST, 1'b0, '0);
    run_query(MODE_FIRST, 1'b1, '0);

    // directed: zero size, oversized register, one bit, just past a word
    write_size('0);
    run_query(MODE_FIRST, 1'b1, '0);
    run_query(MODE_LAST, 1'b0, '0);
    run_query(MODE_NEXT, 1'b0, '0);
    write_size('1);
    run_query(MODE_LAST, 1'b1, '0);
    run_query(MODE_NEXT, 1'b1, 12'(TOTAL_BITS - 1));
    write_size(SIZE_W'(1));
    run_query(MODE_FIRST, 1'b1, '0);
    run_query(MODE_FIRST, 1'b0, '0);
    run_query(MODE_NEXT, 1'b0, 12'd1);
    write_size(SIZE_W'(WORD_BITS + 1));
    run_query(MODE_LAST, 1'b1, '0);
    run_query(MODE_NEXT, 1'b0, 12'(WORD_BITS));

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 85 : 0;
      rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 11 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        write_size(pick_size());
        repeat (SEGMENT_ITEMS) begin
          random_item();
          if ($urandom_range(59, 0) == 0) drain();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
